// ----- src/msrs_pkg.sv -----
// Package: shared types and constants for the multi-stream read scheduler.
`default_nettype none
package msrs_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned ChW   = 3;
  localparam int unsigned FileW = 16;
  localparam int unsigned OffW  = 31;
  localparam int unsigned SizeW = 21;
  localparam int unsigned PrioW = 8;
  localparam logic [SizeW-1:0] BufMax = 21'd1048576;
  localparam logic [SizeW-1:0] BufReset = 21'd65536;

  localparam logic [CmdW-1:0] CMD_CREATE   = 3'd0;
  localparam logic [CmdW-1:0] CMD_RELEASE  = 3'd1;
  localparam logic [CmdW-1:0] CMD_TICK     = 3'd2;
  localparam logic [CmdW-1:0] CMD_CONSUME  = 3'd3;
  localparam logic [CmdW-1:0] CMD_SETPRIO  = 3'd4;

  // per-channel payload held in memory
  typedef struct packed {
    logic [FileW-1:0] file_id;
    logic [OffW-1:0]  read_offset;
    logic [OffW-1:0]  start_offset;
    logic [OffW-1:0]  length;
    logic [OffW-1:0]  bytes_left;
    logic [OffW-1:0]  transferred;
  } entry_t;

  typedef struct packed {
    logic             ok;
    logic [ChW-1:0]   slot;
    logic             read_issue;
    logic [ChW-1:0]   read_channel;
    logic [FileW-1:0] read_file;
    logic [OffW-1:0]  read_offset;
    logic [SizeW-1:0] read_size;
    logic             done_valid;
    logic [ChW-1:0]   done_channel;
    logic [OffW-1:0]  transferred;
    logic             finished;
    logic             ready_res;
  } result_t;

  localparam int unsigned ResW = $bits(result_t);

endpackage
`default_nettype wire

// ----- src/msrs_mem.sv -----
// Channel entry memory: one write port, one registered read port.
`default_nettype none
module msrs_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW = 3
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire msrs_pkg::entry_t    wdata,
  input  wire logic [AW-1:0]       raddr,
  output msrs_pkg::entry_t         rdata
);
  msrs_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/msrs_prio_mem.sv -----
// Priority memory: one write port, one registered read port.
`default_nettype none
module msrs_prio_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW = 3
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [msrs_pkg::PrioW-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic [msrs_pkg::PrioW-1:0]       rdata
);
  logic [msrs_pkg::PrioW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/multi_stream_read_scheduler.sv -----
// Top level: command sequencer over the channel entry and priority memories.
//
//  channel   dir  contents
//  s_axis    in   tdata: cmd, channel, file_id, start_offset, length, loop_flag,
//                 priority_req, read_done, bytes_done
//  m_axis    out  tdata: ok, slot, read_issue, read_channel, read_file,
//                 read_offset, read_size, done_valid, done_channel, transferred,
//                 finished, ready_res
//  cfg       in   buffer_bytes
//
// One word at a time. Release, set priority, idle tick: decode, then output. Create
// and completion: read, modify, write back; consume: read only. Pick tick: a scan,
// a priority memory read per channel, then issue. Reset resets flags and buffer size, not the memories.
// A result waits in the output register; the next word is taken meanwhile.
`default_nettype none
module multi_stream_read_scheduler #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned ALIGN_BYTES = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // cmd[2:0] channel[5:3] file_id[21:6] start_offset[52:22] length[83:53]
  // loop_flag[84] priority_req[92:85] read_done[93] bytes_done[114:94]
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // ok[0] slot[3:1] read_issue[4] read_channel[7:5] read_file[23:8]
  // read_offset[54:24] read_size[75:55] done_valid[76] done_channel[79:77]
  // transferred[110:80] finished[111] ready_res[112]
  output logic [119:0]      m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [20:0]  cfg_data
);
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNTW = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned ALW = $clog2(ALIGN_BYTES);
  localparam logic [msrs_pkg::SizeW-1:0] AlignSz = msrs_pkg::SizeW'(ALIGN_BYTES);
  localparam logic [msrs_pkg::OffW-1:0] Mask31 = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD, S_WB, S_SCAN, S_ISSUE, S_ISSUE2, S_OUT
  } state_t;

  state_t state;
  logic [2:0]  cmd;
  logic [2:0]  ch_in;
  logic [15:0] file_in;
  logic [30:0] start_in, len_in;
  logic        loop_in;
  logic [7:0]  prio_in;
  logic        rdone_in;
  logic [20:0] bdone_in;

  logic [NUM_CHANNELS-1:0] used_f, strm_f, rdy_f, fin_f, end_f, kill_f, loop_f;
  logic        infl_v;
  logic [CW-1:0] infl_ch;
  logic [20:0] buf_bytes;

  logic [CW-1:0] cur;
  logic [CNTW-1:0] scan;
  logic        pick_v;
  logic [CW-1:0] pick;
  logic [7:0]  pick_pr;
  logic        scan_pend;
  logic [CW-1:0] scan_idx;

  msrs_pkg::result_t res;
  msrs_pkg::entry_t  ent_w, ent_r;
  logic        ent_we;
  logic [CW-1:0] ent_ra;
  logic        pr_we;
  logic [CW-1:0] pr_wa, pr_ra;
  logic [7:0]  pr_wd, pr_rd;

  msrs_mem #(.DEPTH(NUM_CHANNELS), .AW(CW)) u_mem (
    .clk(clk), .we(ent_we), .waddr(cur), .wdata(ent_w), .raddr(ent_ra), .rdata(ent_r)
  );
  msrs_prio_mem #(.DEPTH(NUM_CHANNELS), .AW(CW)) u_prio (
    .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd)
  );

  logic ch_ok;
  assign ch_ok = 32'(ch_in) < NUM_CHANNELS;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign ent_ra = (state == S_ISSUE) ? pick : cur;
  assign pr_ra = scan_idx;
  assign scan_idx = scan[CW-1:0];

  logic [CW-1:0] free_idx;
  logic          free_v;
  always_comb begin
    free_idx = '0;
    free_v = 1'b0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!used_f[i]) begin
        free_idx = CW'(i);
        free_v = 1'b1;
      end
    end
  end

  // size computation for the picked channel
  logic [31:0] up_left;
  logic        is_end;
  logic [20:0] size;
  always_comb begin
    up_left = ({1'b0, ent_r.bytes_left} + 32'(ALIGN_BYTES - 1)) >> ALW << ALW;
    is_end = {1'b0, ent_r.bytes_left} < 32'(buf_bytes);
    size = is_end ? up_left[20:0] : buf_bytes;
  end

  // completion arithmetic
  logic [31:0] off_sum;
  logic [30:0] off_sat, left_sub;
  always_comb begin
    off_sum = {1'b0, ent_r.read_offset} + 32'(bdone_in);
    off_sat = off_sum[31] ? Mask31 : off_sum[30:0];
    left_sub = ({10'd0, bdone_in} > ent_r.bytes_left) ? '0
             : ent_r.bytes_left - {10'd0, bdone_in};
  end

  logic [20:0] cfg_rnd;
  always_comb begin
    cfg_rnd = {cfg_data[20:ALW], ALW'(0)};
    if (cfg_rnd < AlignSz) cfg_rnd = AlignSz;
    if (cfg_rnd > msrs_pkg::BufMax) cfg_rnd = msrs_pkg::BufMax;
  end

  always_ff @(posedge clk) begin
    ent_we <= 1'b0;
    pr_we  <= 1'b0;
    if (cfg_valid && cfg_ready) begin
      buf_bytes <= cfg_rnd;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd      <= s_axis_tdata[2:0];
          ch_in    <= s_axis_tdata[5:3];
          file_in  <= s_axis_tdata[21:6];
          start_in <= s_axis_tdata[52:22];
          len_in   <= s_axis_tdata[83:53];
          loop_in  <= s_axis_tdata[84];
          prio_in  <= s_axis_tdata[92:85];
          rdone_in <= s_axis_tdata[93];
          bdone_in <= s_axis_tdata[114:94];
          res      <= '0;
          state    <= S_DECODE;
        end
      end
      S_DECODE: begin
        state <= S_OUT;
        case (cmd)
          msrs_pkg::CMD_CREATE: begin
            if (free_v) begin
              cur <= free_idx;
              used_f[free_idx] <= 1'b1;
              strm_f[free_idx] <= 1'b1;
              rdy_f[free_idx]  <= 1'b0;
              fin_f[free_idx]  <= 1'b0;
              end_f[free_idx]  <= 1'b0;
              kill_f[free_idx] <= 1'b0;
              loop_f[free_idx] <= loop_in;
              pr_we <= 1'b1;
              pr_wa <= free_idx;
              pr_wd <= '0;
              res.ok <= 1'b1;
              res.slot <= 3'(free_idx);
              state <= S_RD;
            end
          end
          msrs_pkg::CMD_RELEASE: begin
            if (ch_ok) begin
              if (infl_v && infl_ch == CW'(ch_in)) begin
                kill_f[CW'(ch_in)] <= 1'b1;
              end else begin
                used_f[CW'(ch_in)] <= 1'b0;
                strm_f[CW'(ch_in)] <= 1'b0;
              end
            end
          end
          msrs_pkg::CMD_TICK: begin
            if (infl_v) begin
              if (rdone_in) begin
                cur <= infl_ch;
                state <= S_RD;
              end
            end else begin
              scan <= '0;
              scan_pend <= 1'b0;
              pick_v <= 1'b0;
              state <= S_SCAN;
            end
          end
          msrs_pkg::CMD_CONSUME: begin
            res.done_channel <= ch_in;
            if (ch_ok) begin
              cur <= CW'(ch_in);
              state <= S_RD;
            end
          end
          msrs_pkg::CMD_SETPRIO: begin
            if (ch_ok) begin
              pr_we <= 1'b1;
              pr_wa <= CW'(ch_in);
              pr_wd <= prio_in;
            end
          end
          default: ;
        endcase
      end
      S_RD: state <= S_WB;
      S_WB: begin
        state <= S_OUT;
        case (cmd)
          // transferred count survives a release and a new create
          msrs_pkg::CMD_CREATE: begin
            ent_w <= '{file_id: file_in, read_offset: start_in, start_offset: start_in,
                       length: len_in, bytes_left: len_in, transferred: ent_r.transferred};
            ent_we <= 1'b1;
          end
          msrs_pkg::CMD_CONSUME: begin
            res.transferred <= ent_r.transferred;
            res.finished <= fin_f[cur];
            res.ready_res <= rdy_f[cur];
            rdy_f[cur] <= 1'b0;
          end
          default: begin
            infl_v <= 1'b0;
            res.done_valid <= 1'b1;
            res.done_channel <= 3'(cur);
            ent_w <= ent_r;
            if (used_f[cur] && kill_f[cur]) begin
              used_f[cur] <= 1'b0;
              strm_f[cur] <= 1'b0;
              kill_f[cur] <= 1'b0;
            end else begin
              rdy_f[cur] <= 1'b1;
              res.ready_res <= 1'b1;
              ent_we <= 1'b1;
              if (end_f[cur]) begin
                ent_w.transferred <= ent_r.bytes_left;
                res.transferred <= ent_r.bytes_left;
                if (loop_f[cur]) begin
                  ent_w.bytes_left <= ent_r.length;
                  ent_w.read_offset <= ent_r.start_offset;
                  end_f[cur] <= 1'b0;
                  res.finished <= fin_f[cur];
                end else begin
                  fin_f[cur] <= 1'b1;
                  res.finished <= 1'b1;
                end
              end else begin
                ent_w.transferred <= {10'd0, bdone_in};
                ent_w.read_offset <= off_sat;
                ent_w.bytes_left <= left_sub;
                res.transferred <= {10'd0, bdone_in};
                res.finished <= fin_f[cur];
              end
            end
          end
        endcase
      end
      S_SCAN: begin
        // pr_rd holds priority of the index issued last cycle
        if (scan_pend) begin
          if (strm_f[cur] && !rdy_f[cur] && !fin_f[cur] &&
              (!pick_v || pick_pr > pr_rd)) begin
            pick_v <= 1'b1;
            pick <= cur;
            pick_pr <= pr_rd;
          end
        end
        if (32'(scan) < NUM_CHANNELS) begin
          cur <= scan_idx;
          scan_pend <= 1'b1;
          scan <= scan + 1'b1;
        end else begin
          scan_pend <= 1'b0;
          state <= S_ISSUE;
        end
      end
      S_ISSUE: begin
        state <= pick_v ? S_ISSUE2 : S_OUT;
        cur <= pick;
      end
      S_ISSUE2: begin
        state <= S_OUT;
        if (is_end) end_f[cur] <= 1'b1;
        res.read_issue <= size != '0;
        res.read_channel <= 3'(cur);
        res.read_file <= ent_r.file_id;
        res.read_offset <= ent_r.read_offset;
        res.read_size <= size;
        infl_v <= 1'b1;
        infl_ch <= cur;
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {(120 - msrs_pkg::ResW)'(0),
            res.ready_res, res.finished, res.transferred, res.done_channel,
            res.done_valid, res.read_size, res.read_offset, res.read_file,
            res.read_channel, res.read_issue, res.slot, res.ok};
          state <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      used_f <= '0; strm_f <= '0; rdy_f <= '0; fin_f <= '0;
      end_f <= '0; kill_f <= '0; loop_f <= '0;
      infl_v <= 1'b0;
      infl_ch <= '0;
      buf_bytes <= msrs_pkg::BufReset;
      ent_we <= 1'b0;
      pr_we <= 1'b0;
    end
  end

  a_kill_inflight: assert property (@(posedge clk) disable iff (rst)
    (kill_f != '0) |-> infl_v) else $error("kill armed with no read in flight");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_infl_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && infl_v) |-> strm_f[infl_ch]) else $error("in-flight channel free");
endmodule
`default_nettype wire
